>>> design/accel_tilt_angles_with_axis_mode_macros.svh
// Assertion macros shared by the tilt angle block.
`ifndef ACCEL_TILT_ANGLES_WITH_AXIS_MODE_MACROS_SVH
`define ACCEL_TILT_ANGLES_WITH_AXIS_MODE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising edge of i_clk, quiet while i_rst_n is low.
`define ACCT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("acct assertion failed");
// Checked on every rising edge of i_clk, reset included.
`define ACCT_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) else $error("acct assertion failed");
`else
`define ACCT_ASSERT(lbl, prop)
`define ACCT_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> design/acct_pkg.sv
// Types, constants and the arctangent table for the tilt angle block.
package acct_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);
    localparam int VEC_W        = 28;
    localparam int ACC_W        = 25;
    localparam logic signed [ACC_W-1:0] QUARTER_TURN = 25'sd2304000;
    localparam logic [16:0] INV_GAIN = 17'd39797;
    localparam logic [1:0] MODE_XY   = 2'd0;
    localparam logic [1:0] MODE_X    = 2'd1;
    localparam logic [1:0] MODE_Y    = 2'd2;

    typedef struct packed {
        logic              kind;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } t_in_item;

    typedef struct packed {
        logic signed [14:0] pitch_centideg;
        logic signed [15:0] roll_centideg;
        logic               show_pitch;
        logic               show_roll;
        logic [1:0]         current_mode;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE, S_STEP1, S_GAIN, S_LOAD2, S_STEP2, S_FIN
    } t_state;

    typedef struct packed {
        logic              mode_adv;
        logic              load1;
        logic              step;
        logic              gain;
        logic              load2;
        logic              capture;
        logic [ITER_W-1:0] iter;
    } t_dp_cmd;

    // atan(2^-i) in 1/256 centidegree.
    function automatic logic signed [ACC_W-1:0] atan_tab(input logic [4:0] idx);
        logic signed [ACC_W-1:0] v;
        unique case (idx)
            5'd0:  v = 25'sd1152000;
            5'd1:  v = 25'sd680065;
            5'd2:  v = 25'sd359328;
            5'd3:  v = 25'sd182400;
            5'd4:  v = 25'sd91554;
            5'd5:  v = 25'sd45822;
            5'd6:  v = 25'sd22916;
            5'd7:  v = 25'sd11459;
            5'd8:  v = 25'sd5730;
            5'd9:  v = 25'sd2865;
            5'd10: v = 25'sd1432;
            5'd11: v = 25'sd716;
            5'd12: v = 25'sd358;
            5'd13: v = 25'sd179;
            5'd14: v = 25'sd90;
            5'd15: v = 25'sd45;
            5'd16: v = 25'sd22;
            5'd17: v = 25'sd11;
            5'd18: v = 25'sd6;
            5'd19: v = 25'sd3;
            5'd20: v = 25'sd1;
            5'd21: v = 25'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> design/accel_tilt_angles_with_axis_mode.sv
// Top level of the accelerometer tilt angle block with axis mode.
//
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_ready      i_in_item  (t_in_item)
// output    out        o_out_valid / i_out_ready    o_out_item (t_out_item)
//
// A sample item reaches the output register by these steps: the first load
// at the edge that takes it, then sixteen roll steps, one gain multiply, one
// load and sixteen pitch steps of the shared CORDIC unit, then one capture
// that waits while the register holds an untaken result; no new item is taken until then.
// A double-click item is taken while idle and gives no result.
// Reset is synchronous and active low; it sets the axis mode to both.
// A result waiting in the output register does not stop the next item being
// taken; only a second finished result waits for the register to empty.
module accel_tilt_angles_with_axis_mode import acct_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_dp_cmd cmd;

    // The controller counts the steps of each pass and issues one command a cycle.
    acct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_in_item.kind),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // The datapath holds the vector, the angle accumulator and the axis mode.
    acct_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (i_in_item),
        .o_item  (o_out_item)
    );

endmodule

>>> design/acct_dp.sv
// Datapath: shared CORDIC vectoring unit, gain multiplier, mode and result registers.
module acct_dp import acct_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    input  t_in_item  i_item,
    output t_out_item o_item
);

    logic signed [VEC_W-1:0] r_x, n_x, r_y, n_y, r_ax, n_ax, r_magc, n_magc;
    logic signed [ACC_W-1:0] r_acc, n_acc, r_roll_acc, n_roll_acc;
    logic                    r_zero, n_zero;
    logic [1:0]              r_mode, n_mode;
    t_out_item               r_out, n_out;

    logic signed [VEC_W-1:0] px, py, dx, dy, mag_sel;
    logic signed [ACC_W-1:0] tab, pitch_acc;
    logic [43:0]             prod;
    logic [4:0]              idx;

    function automatic logic signed [17:0] to_cd(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + (ACC_W+1)'(128);
        return s[ACC_W:8];
    endfunction

    always_comb begin
        idx = 5'(i_cmd.iter);
        tab = atan_tab(idx);
        dx  = r_y >>> i_cmd.iter;
        dy  = r_x >>> i_cmd.iter;
        mag_sel = (r_zero || r_x < 0) ? '0 : r_x;
        prod = 44'(unsigned'(mag_sel[26:0])) * 44'(INV_GAIN) + 44'd32768;
        pitch_acc = r_zero ? '0 : r_acc;
        if (i_cmd.load1) begin
            px = VEC_W'(signed'({i_item.accel_z, 8'h00}));
            py = VEC_W'(signed'({i_item.accel_y, 8'h00}));
        end else begin
            px = r_magc;
            py = r_ax;
        end
    end

    always_comb begin
        logic signed [17:0] rc, pc;
        n_x = r_x; n_y = r_y; n_acc = r_acc; n_zero = r_zero;
        n_ax = r_ax; n_magc = r_magc; n_roll_acc = r_roll_acc;
        n_mode = r_mode; n_out = r_out;
        rc = to_cd(r_roll_acc);
        pc = to_cd(pitch_acc);
        if (i_cmd.mode_adv) begin
            n_mode = (r_mode >= MODE_Y) ? MODE_XY : r_mode + 2'd1;
        end
        if (i_cmd.load1 || i_cmd.load2) begin
            if (i_cmd.load1) begin
                n_ax = VEC_W'(signed'({i_item.accel_x, 8'h00}));
            end
            n_zero = (px == 0) && (py == 0);
            if (px < 0) begin
                if (py >= 0) begin
                    n_x = py; n_y = -px; n_acc = QUARTER_TURN;
                end else begin
                    n_x = -py; n_y = px; n_acc = -QUARTER_TURN;
                end
            end else begin
                n_x = px; n_y = py; n_acc = '0;
            end
        end
        if (i_cmd.step) begin
            if (r_y < 0) begin
                n_x = r_x - dx; n_y = r_y + dy; n_acc = r_acc - tab;
            end else begin
                n_x = r_x + dx; n_y = r_y - dy; n_acc = r_acc + tab;
            end
        end
        if (i_cmd.gain) begin
            n_magc = VEC_W'(prod[43:16]);
            n_roll_acc = r_zero ? '0 : r_acc;
        end
        if (i_cmd.capture) begin
            if (rc > 18'sd18000) rc = 18'sd18000;
            if (rc < -18'sd18000) rc = -18'sd18000;
            if (pc > 18'sd9000) pc = 18'sd9000;
            if (pc < -18'sd9000) pc = -18'sd9000;
            n_out.roll_centideg  = rc[15:0];
            n_out.pitch_centideg = pc[14:0];
            n_out.show_pitch     = (r_mode == MODE_XY) || (r_mode == MODE_X);
            n_out.show_roll      = (r_mode == MODE_XY) || (r_mode == MODE_Y);
            n_out.current_mode   = r_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_XY;
        end else begin
            r_mode <= n_mode;
        end
        r_x <= n_x; r_y <= n_y; r_acc <= n_acc; r_zero <= n_zero;
        r_ax <= n_ax; r_magc <= n_magc; r_roll_acc <= n_roll_acc; r_out <= n_out;
    end

    assign o_item = r_out;

endmodule

>>> design/acct_ctrl.sv
// Controller: sequences the two vectoring passes and owns the handshakes.
`include "accel_tilt_angles_with_axis_mode_macros.svh"
module acct_ctrl import acct_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_kind,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    t_state            r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic              r_out_valid, n_out_valid;
    logic              last;

    assign last = (r_iter == ITER_W'(CORDIC_STEPS - 1));

    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready = 1'b0;
        o_cmd = '0;
        o_cmd.iter = r_iter;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_kind) begin
                        o_cmd.mode_adv = 1'b1;
                    end else begin
                        o_cmd.load1 = 1'b1;
                        n_iter = '0;
                        n_state = S_STEP1;
                    end
                end
            end
            S_STEP1: begin
                o_cmd.step = 1'b1;
                n_iter = r_iter + 1'b1;
                if (last) n_state = S_GAIN;
            end
            S_GAIN: begin
                o_cmd.gain = 1'b1;
                n_state = S_LOAD2;
            end
            S_LOAD2: begin
                o_cmd.load2 = 1'b1;
                n_iter = '0;
                n_state = S_STEP2;
            end
            S_STEP2: begin
                o_cmd.step = 1'b1;
                n_iter = r_iter + 1'b1;
                if (last) n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.capture = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_iter <= n_iter;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `ACCT_ASSERT(a_gain_then_load, r_state == S_GAIN |=> r_state == S_LOAD2)
    `ACCT_ASSERT(a_sample_starts, i_in_valid && o_in_ready && !i_kind |=> r_state == S_STEP1)
    `ACCT_ASSERT(a_fin_holds, r_state == S_FIN && r_out_valid && !i_out_ready |=> r_state == S_FIN)
    `ACCT_ASSERT(a_click_stays_idle, i_in_valid && o_in_ready && i_kind |=> r_state == S_IDLE)

endmodule

>>> test/acct_checker.sv
// Checker that predicts tilt angles and axis mode flags and compares the block's results.
module acct_checker import acct_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_errors,
    output int        o_pending
);

    t_out_item   angle_q[$];
    logic [1:0]  mode_model;

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    // Vectoring pass; returns the angle accumulator and the final x via mag.
    function automatic longint vector_angle(longint vx, longint vy, output longint mag);
        longint acc;
        longint t;
        longint dx;
        longint dy;
        acc = 0;
        if (vx == 0 && vy == 0) begin
            mag = 0;
            return 0;
        end
        if (vx < 0) begin
            t = vx;
            if (vy >= 0) begin
                vx = vy;
                vy = -t;
                acc = QUARTER_TURN;
            end else begin
                vx = -vy;
                vy = t;
                acc = -QUARTER_TURN;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = floor_sh(vy, i);
            dy = floor_sh(vx, i);
            if (vy < 0) begin
                vx -= dx;
                vy += dy;
                acc -= atan_tab(i);
            end else begin
                vx += dx;
                vy -= dy;
                acc += atan_tab(i);
            end
        end
        mag = vx;
        return acc;
    endfunction

    function automatic longint centideg(longint acc, longint lim);
        longint c;
        c = floor_sh(acc + 128, 8);
        if (c > lim) c = lim;
        if (c < -lim) c = -lim;
        return c;
    endfunction

    function automatic t_out_item predict_tilt(t_in_item it, logic [1:0] m);
        t_out_item r;
        longint ax;
        longint ay;
        longint az;
        longint mag;
        longint magc;
        longint unused;
        longint roll;
        longint pitch;
        ax = longint'(it.accel_x) * 256;
        ay = longint'(it.accel_y) * 256;
        az = longint'(it.accel_z) * 256;
        roll = centideg(vector_angle(az, ay, mag), 18000);
        if (mag < 0) mag = 0;
        magc = (mag * longint'(INV_GAIN) + 32768) >>> 16;
        pitch = centideg(vector_angle(magc, ax, unused), 9000);
        r.pitch_centideg = pitch[14:0];
        r.roll_centideg  = roll[15:0];
        r.show_pitch     = (m == MODE_XY || m == MODE_X);
        r.show_roll      = (m == MODE_XY || m == MODE_Y);
        r.current_mode   = m;
        return r;
    endfunction

    assign o_pending = angle_q.size();

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            mode_model <= MODE_XY;
            angle_q.delete();
            o_errors <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (i_in_item.kind)
                    mode_model <= (mode_model >= MODE_Y) ? MODE_XY : mode_model + 2'd1;
                else
                    angle_q.push_back(predict_tilt(i_in_item, mode_model));
            end
            if (i_out_valid && i_out_ready) begin
                if (angle_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_out_item);
                    o_errors <= o_errors + 1;
                end else begin
                    want = angle_q.pop_front();
                    if (want !== i_out_item) begin
                        $display("%0t: mismatch expected pitch %0d roll %0d sp %b sr %b mode %0d",
                                 $time, want.pitch_centideg, want.roll_centideg,
                                 want.show_pitch, want.show_roll, want.current_mode);
                        $display("%0t:          actual pitch %0d roll %0d sp %b sr %b mode %0d",
                                 $time, i_out_item.pitch_centideg, i_out_item.roll_centideg,
                                 i_out_item.show_pitch, i_out_item.show_roll,
                                 i_out_item.current_mode);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

>>> test/accel_tilt_angles_with_axis_mode_tb.sv
// Testbench top for the tilt angle block: stimulus, receiver stalls and verdict.
module accel_tilt_angles_with_axis_mode_tb;
    import acct_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;
    int        errors;
    int        pending;

    // The receiver stalls at random in normal running; hold_off forces a long stall.
    bit        hold_off;
    bit        calm;

    accel_tilt_angles_with_axis_mode DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    acct_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Picks an axis value that favours the extremes and small magnitudes.
    function automatic logic [15:0] pick_axis();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'h0000;
            3:       return 16'($signed($urandom_range(0, 40)) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    // Offers one item and holds it steady until the block accepts it. Valid
    // stays high afterwards so that items can follow back to back; the
    // caller drops it when the sender pauses.
    task automatic send_item(input logic kind, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] z);
        while (!calm && $urandom_range(0, 99) < 10) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid        <= 1'b1;
        in_item.kind    <= kind;
        in_item.accel_x <= x;
        in_item.accel_y <= y;
        in_item.accel_z <= z;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z);
        send_item(1'b0, x, y, z);
    endtask

    // Receiver: random stalls, or none at all while calm, or a long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_off && (calm || $urandom_range(0, 99) >= 10);
    end

    initial begin
        #4000000;
        $display("accel_tilt_angles_with_axis_mode_tb failed");
        $finish;
    end

    initial begin
        in_valid = 1'b0;
        in_item  = '0;
        hold_off = 1'b0;
        calm     = 1'b0;
        i_rst_n  = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: axes at their extremes, the zero vector, negative z with
        // y on each side of zero, and a double-click through every mode
        // including the wrap back to both.
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h7FFF, 16'h0000, 16'h0000);
        send_sample(16'h8000, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'h8000);
        send_sample(16'h0000, 16'h0100, 16'hFF00);
        send_sample(16'h0000, 16'hFF00, 16'hFF00);
        send_sample(16'h0000, 16'h7FFF, 16'h0000);
        send_sample(16'h0000, 16'h8000, 16'h0000);
        send_sample(16'hFFFF, 16'h0001, 16'h0001);
        send_item(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(16'h0100, 16'h0000, 16'h0100);
        send_item(1'b1, 16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h0100, 16'h0100);
        send_item(1'b1, 16'h1234, 16'h0000, 16'h0000);
        send_sample(16'hFF00, 16'h0000, 16'hFF00);
        in_valid <= 1'b0;

        // The sender pauses until every expected result has come in.
        while (pending != 0) @(negedge i_clk);

        // Long receiver hold-off while the sender keeps offering items,
        // so the block fills up and stops taking input.
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(negedge i_clk);
                hold_off = 1'b0;
            end
            begin
                for (int n = 0; n < 6; n++)
                    send_sample(pick_axis(), pick_axis(), pick_axis());
                in_valid <= 1'b0;
            end
        join

        // Random part; a stretch in the middle runs without any idling.
        for (int n = 0; n < 1600; n++) begin
            calm = (n >= 700 && n < 900);
            if ($urandom_range(0, 99) < 8)
                send_item(1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
            else
                send_sample(pick_axis(), pick_axis(), pick_axis());
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (errors == 0)
            $display("accel_tilt_angles_with_axis_mode_tb passed");
        else
            $display("accel_tilt_angles_with_axis_mode_tb failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/acct_pkg.sv
design/acct_dp.sv
design/acct_ctrl.sv
design/accel_tilt_angles_with_axis_mode.sv
test/acct_checker.sv
test/accel_tilt_angles_with_axis_mode_tb.sv
